// ----- src/lwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_pkg
// Shared constants and types of the LIKE wildcard matcher.
// ----------------------------------------------------------------------------
package lwm_pkg;

	localparam int MAX_PATTERN = 32;

	localparam logic [7:0] CH_ANY_RUN = 8'h25;  // '%'
	localparam logic [7:0] CH_ANY_ONE = 8'h5F;  // '_'

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_TEXT   = 2'd2;
	localparam logic [1:0] OP_END    = 2'd3;

	// Broadcast from the top level to every pattern cell.
	typedef struct packed {
		logic       step;     // consume a text byte
		logic       restart;  // reload the active set from position zero
		logic       clear;    // drop the pattern
		logic [7:0] ch;
	} cell_ctl_t;

endpackage

// ----- src/lwm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_if
// Request and result channels of the LIKE wildcard matcher.
// ----------------------------------------------------------------------------
interface lwm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] ch;

	modport source (output valid, output op, output ch, input ready);
	modport sink   (input valid, input op, input ch, output ready);
endinterface

interface lwm_res_if;
	logic valid;
	logic ready;
	logic match;
	logic pattern_overflow;

	modport source (output valid, output match, output pattern_overflow, input ready);
	modport sink   (input valid, input match, input pattern_overflow, output ready);
endinterface

// ----- src/lwm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_cell
// One pattern position: holds a pattern byte and the active bit of its position.
// ----------------------------------------------------------------------------
module lwm_cell #(
	parameter bit ACT_RESET = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lwm_pkg::cell_ctl_t ctl,
	input  logic               wr_en,
	input  logic               adv_in,
	input  logic               carry_in,
	input  logic               init_in,
	output logic               adv_out,
	output logic               carry_out,
	output logic               init_out,
	output logic               act
);

	logic [7:0] pat_q;
	logic       valid_q;
	logic       act_q;
	logic       is_pct;
	logic       hit;
	logic       closed;
	logic       new_pct;

	assign is_pct = valid_q && (pat_q == lwm_pkg::CH_ANY_RUN);
	assign hit    = valid_q && !is_pct &&
		((pat_q == lwm_pkg::CH_ANY_ONE) || (pat_q == ctl.ch));

	// A '%' keeps its own position alive; closure then carries it one further.
	assign closed    = (act_q && is_pct) || adv_in || carry_in;
	assign carry_out = closed && is_pct;
	assign adv_out   = act_q && hit;

	// Restart set under the pattern as it stands after this request.
	assign new_pct  = !ctl.clear && (wr_en ? (ctl.ch == lwm_pkg::CH_ANY_RUN) : is_pct);
	assign init_out = init_in && new_pct;
	assign act      = act_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= ctl.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= ACT_RESET;
		end else begin
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (wr_en) begin
				valid_q <= 1'b1;
			end
			if (ctl.restart) begin
				act_q <= init_in;
			end else if (ctl.step) begin
				act_q <= closed;
			end
		end
	end

endmodule

// ----- src/like_wildcard_matcher.sv -----
`timescale 1ns / 1ps
// An end-of-text request's result is registered, valid the cycle after it is accepted.
// Throughput: one request per cycle while no result waits untaken; all pattern cells update
// in parallel on each text byte, the active set settling through a one-gate-per-cell ripple.
// Reset: empty pattern, no overflow, only position zero active, no result pending.
// The pattern bytes themselves are not reset; a cell reads only once written.
// ----------------------------------------------------------------------------
// like_wildcard_matcher
// SQL LIKE matcher over a row of pattern cells tracking the active position set.
// ----------------------------------------------------------------------------
module like_wildcard_matcher #(
	parameter int MAX_PATTERN = lwm_pkg::MAX_PATTERN
) (
	input  logic     clk,
	input  logic     arst_n,
	lwm_req_if.sink  req,
	lwm_res_if.source res
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic                   req_acc;
	logic [LEN_W-1:0]       len_q;
	logic                   ovf_q;
	logic                   act_last_q;
	logic                   res_valid_q;
	logic                   match_q;
	logic                   res_ovf_q;
	lwm_pkg::cell_ctl_t     ctl;
	logic [MAX_PATTERN-1:0] wr_en;
	logic [MAX_PATTERN:0]   adv_c;
	logic [MAX_PATTERN:0]   carry_c;
	logic [MAX_PATTERN:0]   init_c;
	logic [MAX_PATTERN:0]   act_vec;
	logic                   is_full;

	assign req.ready = !res_valid_q || res.ready;
	assign req_acc   = req.valid && req.ready;
	assign is_full   = (len_q == LEN_W'(MAX_PATTERN));

	always_comb begin
		ctl.step    = 1'b0;
		ctl.restart = 1'b0;
		ctl.clear   = 1'b0;
		ctl.ch      = req.ch;
		if (req_acc) begin
			unique case (req.op)
				lwm_pkg::OP_APPEND: begin
					ctl.restart = 1'b1;
				end
				lwm_pkg::OP_CLEAR: begin
					ctl.restart = 1'b1;
					ctl.clear   = 1'b1;
				end
				lwm_pkg::OP_TEXT: begin
					ctl.step = 1'b1;
				end
				lwm_pkg::OP_END: begin
					ctl.restart = 1'b1;
				end
			endcase
		end
	end

	assign adv_c[0]   = 1'b0;
	assign carry_c[0] = 1'b0;
	assign init_c[0]  = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign wr_en[i] = req_acc && (req.op == lwm_pkg::OP_APPEND) && (len_q == LEN_W'(i));

		lwm_cell #(
			.ACT_RESET(i == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (wr_en[i]),
			.adv_in   (adv_c[i]),
			.carry_in (carry_c[i]),
			.init_in  (init_c[i]),
			.adv_out  (adv_c[i+1]),
			.carry_out(carry_c[i+1]),
			.init_out (init_c[i+1]),
			.act      (act_vec[i])
		);
	end

	// The final position has no pattern byte of its own; it only collects.
	assign act_vec[MAX_PATTERN] = act_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			act_last_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.restart) begin
				act_last_q <= init_c[MAX_PATTERN];
			end else if (ctl.step) begin
				act_last_q <= adv_c[MAX_PATTERN] || carry_c[MAX_PATTERN];
			end
			if (ctl.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (req_acc && (req.op == lwm_pkg::OP_APPEND)) begin
				if (is_full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
			if (req_acc && (req.op == lwm_pkg::OP_END)) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req.op == lwm_pkg::OP_END)) begin
			match_q   <= act_vec[len_q] && !ovf_q;
			res_ovf_q <= ovf_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.match            = match_q;
	assign res.pattern_overflow = res_ovf_q;

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req.op == lwm_pkg::OP_END) |=> res.valid)
		else $error("end-of-text request produced no result");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> is_full)
		else $error("overflow flagged with room left in the store");

	a_match_needs_fit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.match |-> !res.pattern_overflow)
		else $error("match reported for an overflowed pattern");

	a_clear_resets_set: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (act_vec == (MAX_PATTERN + 1)'(1)) && (len_q == '0))
		else $error("clear did not return to position zero");

	a_active_within_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != LEN_W'(MAX_PATTERN)) |-> !act_vec[MAX_PATTERN])
		else $error("active position beyond the pattern length");

endmodule
